>>> rtl/core/atrp_pkg.sv
// shared types, constants and lookup tables of the answer-to-reset parser
`default_nettype none

package atrp_pkg;

  localparam int MAX_ATR_BYTES = 32;
  localparam int CNT_W         = $clog2(MAX_ATR_BYTES + 1);

  localparam int RATIO_W   = 12;
  localparam int DIVISOR_W = 7;
  localparam int DIV_STEPS = RATIO_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [ADDR_W-3:0] REG_DEFAULT_RATIO = '0;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 12'd372;
  localparam logic [RATIO_W-1:0] RATIO_MIN   = 12'd1;
  localparam logic [RATIO_W-1:0] RATIO_MAX   = 12'd2048;

  localparam logic [7:0] TS_DIRECT  = 8'h3B;
  localparam logic [7:0] TS_INVERSE = 8'h3F;

  typedef enum logic [2:0] {
    PH_TS,
    PH_T0,
    PH_IF,
    PH_HIST,
    PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } seq_t;

  typedef enum logic [2:0] {
    CLS_TS,
    CLS_T0,
    CLS_TA,
    CLS_TB,
    CLS_TC,
    CLS_TD,
    CLS_HIST,
    CLS_IGNORED
  } class_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_BAD_TS,
    ERR_RESERVED_FD,
    ERR_TOO_LONG
  } err_t;

  typedef struct packed {
    logic                 start;
    logic [RATIO_W-1:0]   dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  // clock rate conversion factor F, zero for a reserved code
  function automatic logic [RATIO_W-1:0] f_lookup(input logic [3:0] code);
    logic [RATIO_W-1:0] f;
    case (code)
      4'd0:    f = 12'd372;
      4'd1:    f = 12'd372;
      4'd2:    f = 12'd558;
      4'd3:    f = 12'd744;
      4'd4:    f = 12'd1116;
      4'd5:    f = 12'd1488;
      4'd6:    f = 12'd1860;
      4'd9:    f = 12'd512;
      4'd10:   f = 12'd768;
      4'd11:   f = 12'd1024;
      4'd12:   f = 12'd1536;
      4'd13:   f = 12'd2048;
      default: f = '0;
    endcase
    return f;
  endfunction

  // baud rate adjustment factor D, zero for a reserved code
  function automatic logic [DIVISOR_W-1:0] d_lookup(input logic [3:0] code);
    logic [DIVISOR_W-1:0] d;
    case (code)
      4'd1:    d = 7'd1;
      4'd2:    d = 7'd2;
      4'd3:    d = 7'd4;
      4'd4:    d = 7'd8;
      4'd5:    d = 7'd16;
      4'd6:    d = 7'd32;
      4'd7:    d = 7'd64;
      4'd8:    d = 7'd12;
      4'd9:    d = 7'd20;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/atrp_if.sv
// valid/ready channel interfaces for received characters and parsed items
`default_nettype none

interface atrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       new_atr;

  modport source (output valid, output rx_byte, output new_atr, input ready);
  modport sink   (input valid, input rx_byte, input new_atr, output ready);
endinterface

interface atrp_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  atr_byte;
  logic [2:0]                  byte_class;
  logic [5:0]                  byte_index;
  logic [3:0]                  group_index;
  logic [atrp_pkg::RATIO_W-1:0] clock_ratio;
  logic                        atr_done;
  logic [1:0]                  error_code;

  modport source (output valid, output atr_byte, output byte_class, output byte_index,
                  output group_index, output clock_ratio, output atr_done,
                  output error_code, input ready);
  modport sink   (input valid, input atr_byte, input byte_class, input byte_index,
                  input group_index, input clock_ratio, input atr_done,
                  input error_code, output ready);
endinterface

`default_nettype wire

>>> rtl/core/atrp_div.sv
// restoring divider, one quotient bit per cycle, for the F/D clock ratio
`default_nettype none

module atrp_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire atrp_pkg::div_req_t            req,
  output logic                               done,
  output logic [atrp_pkg::RATIO_W-1:0]       quotient
);

  logic [atrp_pkg::STEP_W-1:0]    cnt;
  logic [atrp_pkg::DIVISOR_W-1:0] rem;
  logic [atrp_pkg::DIVISOR_W-1:0] divisor;
  logic [atrp_pkg::RATIO_W-1:0]   quo;

  logic [atrp_pkg::DIVISOR_W:0]   trial;
  logic [atrp_pkg::DIVISOR_W:0]   diff;
  logic                           fits;
  logic [atrp_pkg::DIVISOR_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[atrp_pkg::RATIO_W-1]};
    diff     = trial - {1'b0, divisor};
    fits     = (trial >= {1'b0, divisor});
    // remainder stays below the divisor, so the top bit drops out
    rem_next = fits ? diff[atrp_pkg::DIVISOR_W-1:0] : trial[atrp_pkg::DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= atrp_pkg::STEP_W'(atrp_pkg::DIV_STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (cnt != '0) begin
      rem <= rem_next;
      quo <= {quo[atrp_pkg::RATIO_W-2:0], fits};
    end
  end

  assign done     = (cnt == atrp_pkg::STEP_W'(1));
  assign quotient = quo;

endmodule

`default_nettype wire

>>> rtl/core/atrp_cfg.sv
// apb register holding the default clock ratio
`default_nettype none

module atrp_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [atrp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [atrp_pkg::DATA_W-1:0]  pwdata,
  output logic [atrp_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  output logic [atrp_pkg::RATIO_W-1:0]      default_ratio
);

  logic                           sel_ratio;
  logic [atrp_pkg::RATIO_W-1:0]   wr_raw;
  logic [atrp_pkg::RATIO_W-1:0]   wr_clamped;

  assign sel_ratio = (paddr[atrp_pkg::ADDR_W-1:2] == atrp_pkg::REG_DEFAULT_RATIO);
  assign wr_raw    = pwdata[atrp_pkg::RATIO_W-1:0];

  always_comb begin
    if (wr_raw < atrp_pkg::RATIO_MIN) begin
      wr_clamped = atrp_pkg::RATIO_MIN;
    end else if (wr_raw > atrp_pkg::RATIO_MAX) begin
      wr_clamped = atrp_pkg::RATIO_MAX;
    end else begin
      wr_clamped = wr_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_ratio <= atrp_pkg::RATIO_RESET;
    end else if (psel && penable && pwrite && sel_ratio) begin
      default_ratio <= wr_clamped;
    end
  end

  assign pready = 1'b1;
  assign prdata = sel_ratio ? atrp_pkg::DATA_W'(default_ratio) : '0;

endmodule

`default_nettype wire

>>> rtl/core/iso7816_atr_parser_core.sv
// iso 7816-3 answer-to-reset parser: sequencer, parse state and result register
// an item is accepted only while the sequencer is idle; its result becomes valid once
// the restoring divider that forms F/D has finished and the item has been committed
// no new item is taken until the last one is committed to the output register; a stalled
// result holds the next item in its final step until the output register frees
// synchronous reset returns to expect-TS with counters and errors cleared, ratio 372
`default_nettype none

module iso7816_atr_parser_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [atrp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [atrp_pkg::DATA_W-1:0]  pwdata,
  output logic [atrp_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  atrp_in_if.sink                           in_ch,
  atrp_out_if.source                        out_ch
);

  localparam logic [atrp_pkg::CNT_W-1:0] CNT_MAX =
    atrp_pkg::CNT_W'(atrp_pkg::MAX_ATR_BYTES);

  logic [atrp_pkg::RATIO_W-1:0] default_ratio;

  atrp_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .default_ratio (default_ratio)
  );

  // sequencer
  atrp_pkg::seq_t state, state_next;
  logic           in_take;
  logic           commit;
  logic           div_done;
  logic [atrp_pkg::RATIO_W-1:0] quotient;
  atrp_pkg::div_req_t div_req;

  always_comb begin
    state_next = state;
    case (state)
      atrp_pkg::ST_IDLE: if (in_ch.valid) state_next = atrp_pkg::ST_DIV;
      atrp_pkg::ST_DIV:  if (div_done) state_next = atrp_pkg::ST_OUT;
      atrp_pkg::ST_OUT:  if (!out_ch.valid || out_ch.ready) state_next = atrp_pkg::ST_IDLE;
      default:           state_next = atrp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    commit      = 1'b0;
    case (state)
      atrp_pkg::ST_IDLE: in_ch.ready = !rst;
      atrp_pkg::ST_OUT:  commit = !out_ch.valid || out_ch.ready;
      default: begin
        in_ch.ready = 1'b0;
        commit      = 1'b0;
      end
    endcase
  end

  assign in_take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atrp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // the quotient is formed for every item and used only for a valid TA1
  assign div_req.start    = in_take;
  assign div_req.dividend = atrp_pkg::f_lookup(in_ch.rx_byte[7:4]);
  assign div_req.divisor  = atrp_pkg::d_lookup(in_ch.rx_byte[3:0]);

  atrp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  logic [7:0] byte_q;
  logic       fresh_q;

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_q  <= in_ch.rx_byte;
      fresh_q <= in_ch.new_atr;
    end
  end

  // parse state
  atrp_pkg::phase_t              phase, phase_next;
  logic [3:0]                    mask, mask_next;
  logic [3:0]                    hist, hist_next;
  logic [3:0]                    group, group_next;
  logic [atrp_pkg::CNT_W-1:0]    count, count_next;
  logic [atrp_pkg::RATIO_W-1:0]  ratio, ratio_next;
  atrp_pkg::err_t                err, err_next;

  atrp_pkg::class_t              cls;
  logic [atrp_pkg::CNT_W-1:0]    idx;
  logic [3:0]                    grp;
  logic                          done;
  logic                          fd_reserved;

  assign fd_reserved = (atrp_pkg::f_lookup(byte_q[7:4]) == '0) ||
                       (atrp_pkg::d_lookup(byte_q[3:0]) == '0);

  always_comb begin
    phase_next = phase;
    mask_next  = mask;
    hist_next  = hist;
    group_next = group;
    count_next = count;
    ratio_next = ratio;
    err_next   = err;
    cls        = atrp_pkg::CLS_IGNORED;
    idx        = count;
    grp        = '0;
    done       = 1'b0;
    if (fresh_q || phase == atrp_pkg::PH_TS) begin
      count_next = atrp_pkg::CNT_W'(1);
      group_next = '0;
      mask_next  = '0;
      hist_next  = '0;
      err_next   = atrp_pkg::ERR_NONE;
      ratio_next = default_ratio;
      cls        = atrp_pkg::CLS_TS;
      idx        = '0;
      if (byte_q == atrp_pkg::TS_DIRECT || byte_q == atrp_pkg::TS_INVERSE) begin
        phase_next = atrp_pkg::PH_T0;
      end else begin
        err_next   = atrp_pkg::ERR_BAD_TS;
        phase_next = atrp_pkg::PH_IDLE;
        done       = 1'b1;
      end
    end else if (!(phase == atrp_pkg::PH_T0 || phase == atrp_pkg::PH_IF ||
                   phase == atrp_pkg::PH_HIST)) begin
      // after the end of an atr: echo only
      phase_next = atrp_pkg::PH_IDLE;
    end else if (count >= CNT_MAX) begin
      idx        = CNT_MAX;
      count_next = CNT_MAX;
      err_next   = atrp_pkg::ERR_TOO_LONG;
      ratio_next = default_ratio;
      phase_next = atrp_pkg::PH_IDLE;
      done       = 1'b1;
    end else begin
      count_next = count + 1'b1;
      case (phase)
        atrp_pkg::PH_T0: begin
          cls        = atrp_pkg::CLS_T0;
          mask_next  = byte_q[7:4];
          hist_next  = byte_q[3:0];
          group_next = 4'd1;
          if (byte_q[7:4] != '0) begin
            phase_next = atrp_pkg::PH_IF;
          end else if (byte_q[3:0] == '0) begin
            phase_next = atrp_pkg::PH_IDLE;
            done       = 1'b1;
          end else begin
            phase_next = atrp_pkg::PH_HIST;
          end
        end
        atrp_pkg::PH_IF: begin
          grp = group;
          if (mask[0]) begin
            cls       = atrp_pkg::CLS_TA;
            mask_next = mask & 4'hE;
            if (group == 4'd1) begin
              if (fd_reserved) begin
                err_next   = atrp_pkg::ERR_RESERVED_FD;
                ratio_next = default_ratio;
              end else begin
                ratio_next = quotient;
              end
            end
          end else if (mask[1]) begin
            cls       = atrp_pkg::CLS_TB;
            mask_next = mask & 4'hC;
          end else if (mask[2]) begin
            cls       = atrp_pkg::CLS_TC;
            mask_next = mask & 4'h8;
          end else begin
            cls       = atrp_pkg::CLS_TD;
            mask_next = byte_q[7:4];
            if (group < 4'd15) group_next = group + 1'b1;
          end
          if (mask_next == '0) begin
            if (hist == '0) begin
              phase_next = atrp_pkg::PH_IDLE;
              done       = 1'b1;
            end else begin
              phase_next = atrp_pkg::PH_HIST;
            end
          end
        end
        default: begin
          cls = atrp_pkg::CLS_HIST;
          if (hist != '0) hist_next = hist - 1'b1;
          if (hist_next == '0) begin
            phase_next = atrp_pkg::PH_IDLE;
            done       = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= atrp_pkg::PH_TS;
      mask  <= '0;
      hist  <= '0;
      group <= '0;
      count <= '0;
      ratio <= atrp_pkg::RATIO_RESET;
      err   <= atrp_pkg::ERR_NONE;
    end else if (commit) begin
      phase <= phase_next;
      mask  <= mask_next;
      hist  <= hist_next;
      group <= group_next;
      count <= count_next;
      ratio <= ratio_next;
      err   <= err_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (commit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_ch.atr_byte    <= byte_q;
      out_ch.byte_class  <= cls;
      out_ch.byte_index  <= 6'(idx);
      out_ch.group_index <= grp;
      out_ch.clock_ratio <= ratio_next;
      out_ch.atr_done    <= done;
      out_ch.error_code  <= err_next;
    end
  end

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_ch.valid)
    else $error("committed item not presented");

  a_div_in_seq: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == atrp_pkg::ST_DIV)
    else $error("divider finished outside the divide step");

  a_ts_index: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.byte_class == atrp_pkg::CLS_TS) |-> out_ch.byte_index == '0)
    else $error("ts item with nonzero index");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.clock_ratio != '0 && out_ch.clock_ratio <= atrp_pkg::RATIO_MAX))
    else $error("clock ratio out of range");

endmodule

`default_nettype wire
